/* hdl/mer_pkg.sv */
// shared types, widths and constants for the midpoint ellipse rasterizer
// no dependencies; imported by every module of the block
`default_nettype none

package mer_pkg;

    localparam int RADIUS_BITS = 9;
    localparam int COORD_BITS  = 10;
    localparam int PIX_W       = 12;
    localparam int OFS_W       = COORD_BITS + 2;
    localparam int SQ_W        = 2 * RADIUS_BITS;
    localparam int WIDE_W      = (RADIUS_BITS > OFS_W) ? RADIUS_BITS : OFS_W;
    localparam int SLOPE_W     = 2 * RADIUS_BITS + WIDE_W + 2;
    localparam int DV_W        = 2 * RADIUS_BITS + 2 * OFS_W + 4;
    localparam int MUL_W       = (2 * OFS_W + 3 > 2 * RADIUS_BITS + 1) ?
                                 2 * OFS_W + 3 : 2 * RADIUS_BITS + 1;
    localparam int CFG_W       = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 2 * PIX_W;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_B = 2'd3;

    localparam logic [COORD_BITS-1:0]  CENTER_X_RST = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0]  CENTER_Y_RST = COORD_BITS'(240);
    localparam logic [RADIUS_BITS-1:0] RADIUS_A_RST = RADIUS_BITS'(100);
    localparam logic [RADIUS_BITS-1:0] RADIUS_B_RST = RADIUS_BITS'(75);

    localparam logic [1:0] LAST_BEAT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RMUL,
        ST_RSET,
        ST_TEST,
        ST_EMIT,
        ST_STEP,
        ST_DEC,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_E3,
        ST_E4,
        ST_E5
    } state_t;

    typedef enum logic [2:0] {
        MS_TX,
        MS_BS_T,
        MS_TY,
        MS_AS_T,
        MS_AS_BS,
        MS_AS_B
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD4,
        ACC_SUB4
    } acc_op_t;

    typedef struct packed {
        logic     snap;
        logic     rst_init;
        logic     emit;
        logic [1:0] beat;
        logic     clr_active;
        logic     step;
        logic     dec;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     set_r2;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic fin;
        logic go_r2;
        logic out_free;
    } stat_t;

    // {neg_y, neg_x} for each beat of a step
    function automatic logic [1:0] pix_signs(input logic [1:0] beat, input logic r2);
        logic [1:0] s;
        unique case (beat)
            2'd0:    s = 2'b00;
            2'd1:    s = 2'b11;
            2'd2:    s = r2 ? 2'b01 : 2'b10;
            default: s = r2 ? 2'b10 : 2'b01;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* hdl/midpoint_ellipse_rasterizer.sv */
// ellipse rasterizer top: an advance beat is taken in the idle state, its four pixels
// leave one per cycle while the output is free, then STEP and DEC update the walk
// unless it was the final step; the step that enters region two adds E0..E5 (shared
// multiplier, one product per cycle); a restart beat runs RMUL, RSET and TEST, and
// E0..E5 if the walk starts in region two; an advance while no walk runs is dropped;
// reset clears the walk (idle until a restart) and loads the default centre and radii
`default_nettype none

module midpoint_ellipse_rasterizer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mer_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] restart
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mer_pkg::M_TDATA_W-1:0]        m_tdata,   // [11:0] pixel_x, [23:12] pixel_y
    output logic                                 m_tlast,
    output logic                                 m_tuser,   // [0] finished
    input  wire logic                            cfg_we,
    input  wire logic [mer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mer_pkg::CFG_W-1:0]       cfg_data
);
    import mer_pkg::*;

    logic [COORD_BITS-1:0]  center_x_reg, center_y_reg;
    logic [RADIUS_BITS-1:0] radius_a_reg, radius_b_reg;
    logic [PIX_W-1:0]       pixel_x, pixel_y;
    cmd_t                   cmd;
    stat_t                  st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            radius_a_reg <= RADIUS_A_RST;
            radius_b_reg <= RADIUS_B_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[COORD_BITS-1:0];
                REG_RADIUS_A: radius_a_reg <= cfg_data[RADIUS_BITS-1:0];
                REG_RADIUS_B: radius_b_reg <= cfg_data[RADIUS_BITS-1:0];
                default:      ;
            endcase
        end
    end

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .st       (st),
        .cmd      (cmd)
    );

    mer_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .radius_a     (radius_a_reg),
        .radius_b     (radius_b_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last_of_step (m_tlast),
        .finished     (m_tuser)
    );

    assign m_tdata = {pixel_y, pixel_x};

endmodule

`default_nettype wire

/* hdl/mer_ctrl.sv */
// sequencer for the ellipse rasterizer: input handshake, pixel beats,
// step update and the multiply sequence for region two; uses mer_pkg
`default_nettype none

module mer_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic           restart,
    input  wire mer_pkg::stat_t st,
    output mer_pkg::cmd_t       cmd
);
    import mer_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] beat_reg, beat_next;
    logic       beat_done;

    assign beat_done = (state_reg == ST_EMIT) && st.out_free && (beat_reg == LAST_BEAT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            beat_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            beat_reg  <= beat_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        beat_next  = beat_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                beat_next = 2'd0;
                if (s_tvalid)
                begin
                    if (restart)
                        state_next = ST_RMUL;
                    else if (st.active)
                        state_next = ST_EMIT;
                end
            end
            ST_RMUL: state_next = ST_RSET;
            ST_RSET: state_next = ST_TEST;
            ST_TEST: state_next = st.go_r2 ? ST_E0 : ST_IDLE;
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    beat_next = beat_reg + 2'd1;
                    if (beat_done)
                        state_next = st.fin ? ST_IDLE : ST_STEP;
                end
            end
            ST_STEP: state_next = ST_DEC;
            ST_DEC:  state_next = st.go_r2 ? ST_E0 : ST_IDLE;
            ST_E0:   state_next = ST_E1;
            ST_E1:   state_next = ST_E2;
            ST_E2:   state_next = ST_E3;
            ST_E3:   state_next = ST_E4;
            ST_E4:   state_next = ST_E5;
            ST_E5:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.mul_sel    = MS_AS_BS;
        cmd.acc_op     = ACC_NONE;
        cmd.beat       = beat_reg;
        unique case (state_reg)
            ST_IDLE: cmd.snap = s_tvalid;
            ST_RMUL: cmd.mul_sel = MS_AS_B;
            ST_RSET: cmd.rst_init = 1'b1;
            ST_EMIT:
            begin
                cmd.emit       = st.out_free;
                cmd.clr_active = beat_done && st.fin;
            end
            ST_STEP: cmd.step = 1'b1;
            ST_DEC:  cmd.dec = 1'b1;
            ST_E0:   cmd.mul_sel = MS_TX;
            ST_E1:   cmd.mul_sel = MS_BS_T;
            ST_E2:
            begin
                cmd.mul_sel = MS_TY;
                cmd.acc_op  = ACC_LOAD;
            end
            ST_E3:   cmd.mul_sel = MS_AS_T;
            ST_E4:
            begin
                cmd.mul_sel = MS_AS_BS;
                cmd.acc_op  = ACC_ADD4;
            end
            ST_E5:
            begin
                cmd.acc_op = ACC_SUB4;
                cmd.set_r2 = 1'b1;
            end
            default: cmd.snap = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/mer_dp.sv */
// datapath of the ellipse rasterizer: walk state, shared multiplier,
// decision update and the pixel output register; uses mer_pkg
`default_nettype none

module mer_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mer_pkg::cmd_t                    cmd,
    output mer_pkg::stat_t                        st,
    input  wire logic [mer_pkg::COORD_BITS-1:0]   center_x,
    input  wire logic [mer_pkg::COORD_BITS-1:0]   center_y,
    input  wire logic [mer_pkg::RADIUS_BITS-1:0]  radius_a,
    input  wire logic [mer_pkg::RADIUS_BITS-1:0]  radius_b,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [mer_pkg::PIX_W-1:0]             pixel_x,
    output logic [mer_pkg::PIX_W-1:0]             pixel_y,
    output logic                                  last_of_step,
    output logic                                  finished
);
    import mer_pkg::*;

    logic signed [OFS_W-1:0]   x_reg, y_reg;
    logic signed [SLOPE_W-1:0] xs_reg, ys_reg;
    logic signed [DV_W-1:0]    dv_reg;
    logic                      r2_reg, active_reg;

    logic [SQ_W-1:0]           as_reg, bs_reg;
    logic [RADIUS_BITS-1:0]    b_reg;
    logic [SQ_W-1:0]           sq_a_w, sq_b_w;

    logic signed [DV_W-1:0]    prod_reg;
    logic signed [MUL_W-1:0]   op_a, op_b;
    logic signed [2*MUL_W-1:0] prod_w;
    logic signed [OFS_W:0]     tx_w;
    logic signed [OFS_W-1:0]   ty_w;

    logic                      valid_reg, last_reg, fin_reg;
    logic [PIX_W-1:0]          px_reg, py_reg;
    logic [PIX_W-1:0]          px_w, py_w;
    logic [1:0]                signs;

    logic signed [SLOPE_W-1:0] two_as, two_bs;
    logic                      dv_neg, dv_pos, fin_w;
    logic signed [SLOPE_W+1:0] dsum;
    logic signed [DV_W-1:0]    dsum_ext;

    assign sq_a_w = SQ_W'(radius_a) * SQ_W'(radius_a);
    assign sq_b_w = SQ_W'(radius_b) * SQ_W'(radius_b);

    assign two_as = SLOPE_W'({as_reg, 1'b0});
    assign two_bs = SLOPE_W'({bs_reg, 1'b0});
    assign dv_neg = dv_reg[DV_W-1];
    assign dv_pos = !dv_reg[DV_W-1] && (dv_reg != '0);
    assign fin_w  = r2_reg && (y_reg[OFS_W-1] || (y_reg == '0));

    assign st.active   = active_reg;
    assign st.fin      = fin_w;
    assign st.go_r2    = !r2_reg && (xs_reg >= ys_reg);
    assign st.out_free = !valid_reg || m_tready;

    // operand selection for the shared multiplier
    assign tx_w = {x_reg, 1'b1};
    assign ty_w = y_reg - OFS_W'(1);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul_sel)
            MS_TX:
            begin
                op_a = MUL_W'(tx_w);
                op_b = MUL_W'(tx_w);
            end
            MS_BS_T:
            begin
                op_a = MUL_W'(bs_reg);
                op_b = prod_reg[MUL_W-1:0];
            end
            MS_TY:
            begin
                op_a = MUL_W'(ty_w);
                op_b = MUL_W'(ty_w);
            end
            MS_AS_T:
            begin
                op_a = MUL_W'(as_reg);
                op_b = prod_reg[MUL_W-1:0];
            end
            MS_AS_BS:
            begin
                op_a = MUL_W'(as_reg);
                op_b = MUL_W'(bs_reg);
            end
            MS_AS_B:
            begin
                op_a = MUL_W'(as_reg);
                op_b = MUL_W'(b_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_w = (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);

    // decision increment, shared by both regions
    always_comb
    begin
        if (!r2_reg)
        begin
            if (dv_neg)
                dsum = (SLOPE_W+2)'(xs_reg) + (SLOPE_W+2)'(bs_reg);
            else
                dsum = (SLOPE_W+2)'(xs_reg) - (SLOPE_W+2)'(ys_reg)
                     + (SLOPE_W+2)'(bs_reg);
        end
        else
        begin
            if (dv_pos)
                dsum = (SLOPE_W+2)'(as_reg) - (SLOPE_W+2)'(ys_reg);
            else
                dsum = (SLOPE_W+2)'(xs_reg) - (SLOPE_W+2)'(ys_reg)
                     + (SLOPE_W+2)'(as_reg);
        end
        dsum_ext = DV_W'(dsum);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_w[DV_W-1:0];
        if (cmd.snap)
        begin
            as_reg <= sq_a_w;
            bs_reg <= sq_b_w;
            b_reg  <= radius_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            xs_reg     <= '0;
            ys_reg     <= '0;
            dv_reg     <= '0;
            r2_reg     <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rst_init)
            begin
                x_reg      <= '0;
                y_reg      <= OFS_W'(b_reg);
                xs_reg     <= '0;
                ys_reg     <= SLOPE_W'({prod_reg, 1'b0});
                dv_reg     <= DV_W'({bs_reg, 2'b00}) - (prod_reg <<< 2) + DV_W'(as_reg);
                r2_reg     <= 1'b0;
                active_reg <= 1'b1;
            end
            if (cmd.clr_active)
                active_reg <= 1'b0;
            if (cmd.step)
            begin
                if (!r2_reg)
                begin
                    x_reg  <= x_reg + OFS_W'(1);
                    xs_reg <= xs_reg + two_bs;
                    if (!dv_neg)
                    begin
                        y_reg  <= y_reg - OFS_W'(1);
                        ys_reg <= ys_reg - two_as;
                    end
                end
                else
                begin
                    y_reg  <= y_reg - OFS_W'(1);
                    ys_reg <= ys_reg - two_as;
                    if (!dv_pos)
                    begin
                        x_reg  <= x_reg + OFS_W'(1);
                        xs_reg <= xs_reg + two_bs;
                    end
                end
            end
            if (cmd.dec)
                dv_reg <= dv_reg + (dsum_ext <<< 2);
            case (cmd.acc_op)
                ACC_LOAD: dv_reg <= prod_reg;
                ACC_ADD4: dv_reg <= dv_reg + (prod_reg <<< 2);
                ACC_SUB4: dv_reg <= dv_reg - (prod_reg <<< 2);
                default:  ;
            endcase
            if (cmd.set_r2)
                r2_reg <= 1'b1;
        end
    end

    // pixel of the current beat
    assign signs = pix_signs(cmd.beat, r2_reg);
    assign px_w  = signs[0] ? PIX_W'(center_x) - PIX_W'(x_reg)
                            : PIX_W'(center_x) + PIX_W'(x_reg);
    assign py_w  = signs[1] ? PIX_W'(center_y) - PIX_W'(y_reg)
                            : PIX_W'(center_y) + PIX_W'(y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            px_reg   <= px_w;
            py_reg   <= py_w;
            last_reg <= (cmd.beat == LAST_BEAT);
            fin_reg  <= fin_w;
        end
    end

    assign m_tvalid     = valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign last_of_step = last_reg;
    assign finished     = fin_reg;

endmodule

`default_nettype wire

/* dv/tb_midpoint_ellipse_rasterizer.sv */
// self-checking bench for midpoint_ellipse_rasterizer: random stream stimulus with a
// bit-accurate ellipse walk predictor and an in-order pixel scoreboard
// depends on mer_pkg and the rasterizer top level
`timescale 1ns / 100ps

module tb_midpoint_ellipse_rasterizer;

    import mer_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 420;
    localparam int SETTLE_CYC   = 40;
    localparam int LONG_STALL   = 300;
    localparam int MAX_REPORTS  = 50;
    localparam int SMALL_RADIUS = 12;

    localparam logic [S_TDATA_W-1:0] BEAT_ADVANCE = S_TDATA_W'(0);
    localparam logic [S_TDATA_W-1:0] BEAT_RESTART = S_TDATA_W'(1);

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             last;
        logic             fin;
    } pixel_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    midpoint_ellipse_rasterizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [0] restart
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [11:0] pixel_x, [23:12] pixel_y
        .m_tlast   (m_tlast),    // last_of_step
        .m_tuser   (m_tuser),    // [0] finished
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers and the walk
    logic [COORD_BITS-1:0]  cen_x = CENTER_X_RST;
    logic [COORD_BITS-1:0]  cen_y = CENTER_Y_RST;
    logic [RADIUS_BITS-1:0] rad_a = RADIUS_A_RST;
    logic [RADIUS_BITS-1:0] rad_b = RADIUS_B_RST;
    longint walk_x, walk_y, dacc, slope_x, slope_y;
    logic   walk_r2 = 1'b0;
    logic   walk_on = 1'b0;

    pixel_t                 pixel_due[$];
    logic [S_TDATA_W-1:0]   pending[$];
    logic [S_TDATA_W-1:0]   batch[$];

    int  pushed = 0, taken = 0, errors = 0, cycles = 0;
    int  restarts = 0, pixels_checked = 0, final_pixels = 0, phases = 0;
    int  src_gap = 0, sink_gap = 0, stall_left = 0;
    int  stall_ask = 0, stall_seen = 0;
    bit  no_idle = 1'b0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t ns: timed out, %0d pixels still expected", $time, pixel_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic enter_r2();
        longint asq, bsq, tx, ty;
        asq = longint'(rad_a) * longint'(rad_a);
        bsq = longint'(rad_b) * longint'(rad_b);
        tx = 2 * walk_x + 1;
        ty = walk_y - 1;
        walk_r2 = 1'b1;
        dacc = bsq * tx * tx + 4 * asq * ty * ty - 4 * asq * bsq;
    endtask

    task automatic emit_pixel(input int sx, input int sy, input logic last, input logic fin);
        longint px, py;
        pixel_t p;
        px = longint'(cen_x) + sx * walk_x;
        py = longint'(cen_y) + sy * walk_y;
        p.px   = px[PIX_W-1:0];
        p.py   = py[PIX_W-1:0];
        p.last = last;
        p.fin  = fin;
        pixel_due.push_back(p);
    endtask

    // one input beat through the walk, queueing the pixels it produces
    task automatic ellipse_step(input logic restart);
        longint asq, bsq;
        logic fin;
        asq = longint'(rad_a) * longint'(rad_a);
        bsq = longint'(rad_b) * longint'(rad_b);
        if (restart) begin
            walk_x  = 0;
            walk_y  = longint'(rad_b);
            slope_x = 0;
            slope_y = 2 * asq * walk_y;
            dacc    = 4 * bsq - 4 * asq * walk_y + asq;
            walk_r2 = 1'b0;
            walk_on = 1'b1;
            if (slope_x >= slope_y)
                enter_r2();
            return;
        end
        if (!walk_on)
            return;
        fin = walk_r2 && (walk_y <= 0);
        emit_pixel(1, 1, 1'b0, fin);
        emit_pixel(-1, -1, 1'b0, fin);
        if (!walk_r2) begin
            emit_pixel(1, -1, 1'b0, fin);
            emit_pixel(-1, 1, 1'b1, fin);
        end else begin
            emit_pixel(-1, 1, 1'b0, fin);
            emit_pixel(1, -1, 1'b1, fin);
        end
        if (fin) begin
            walk_on = 1'b0;
            return;
        end
        if (!walk_r2) begin
            walk_x++;
            slope_x += 2 * bsq;
            if (dacc < 0)
                dacc += 4 * (slope_x + bsq);
            else begin
                walk_y--;
                slope_y -= 2 * asq;
                dacc += 4 * (slope_x - slope_y + bsq);
            end
            if (slope_x >= slope_y)
                enter_r2();
        end else begin
            walk_y--;
            slope_y -= 2 * asq;
            if (dacc > 0)
                dacc += 4 * (asq - slope_y);
            else begin
                walk_x++;
                slope_x += 2 * bsq;
                dacc += 4 * (slope_x - slope_y + asq);
            end
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endtask

    // source side: random gap before each beat unless a burst is running
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready)
                src_gap = no_idle ? 0 : $urandom_range(0, 4);
            if (!s_tvalid || s_tready) begin
                if (src_gap == 0 && pending.size() != 0) begin
                    s_tdata  <= pending.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    if (src_gap != 0)
                        src_gap--;
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: per-beat wait, plus a long hold-off when asked for one
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            sink_gap = 0;
            stall_left = 0;
        end else begin
            if (stall_ask != stall_seen) begin
                stall_seen = stall_ask;
                stall_left = LONG_STALL;
            end
            if (m_tvalid && m_tready)
                sink_gap = no_idle ? 0 : $urandom_range(0, 4);
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else
                m_tready <= 1'b1;
        end
    end

    // scoreboard: check the output beat first, then predict from the input beat
    always @(posedge clk) begin
        pixel_t exp_pix;
        if (rst_n && m_tvalid && m_tready) begin
            pixels_checked++;
            if (m_tuser)
                final_pixels++;
            if (pixel_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: unexpected pixel, expected none, actual (%0d,%0d)",
                             $time, $signed(m_tdata[11:0]), $signed(m_tdata[23:12]));
            end else begin
                exp_pix = pixel_due.pop_front();
                check_field("pixel_x", $signed(exp_pix.px), $signed(m_tdata[11:0]));
                check_field("pixel_y", $signed(exp_pix.py), $signed(m_tdata[23:12]));
                check_field("last_of_step", exp_pix.last, m_tlast);
                check_field("finished", exp_pix.fin, m_tuser);
            end
        end
        if (rst_n && s_tvalid && s_tready) begin
            taken++;
            if (s_tdata[0])
                restarts++;
            ellipse_step(s_tdata[0]);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_CENTER_X: cen_x = val[COORD_BITS-1:0];
            REG_CENTER_Y: cen_y = val[COORD_BITS-1:0];
            REG_RADIUS_A: rad_a = val[RADIUS_BITS-1:0];
            REG_RADIUS_B: rad_b = val[RADIUS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_ellipse(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                               input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] rb);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS_A, ra);
        write_reg(REG_RADIUS_B, rb);
        phases++;
    endtask

    task automatic launch(input bit burst, input bit hold_sink);
        @(negedge clk);
        no_idle = burst;
        if (hold_sink)
            stall_ask++;
        foreach (batch[k])
            pending.push_back(batch[k]);
        pushed += batch.size();
        batch.delete();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (taken != pushed || pixel_due.size() != 0)
            @(negedge clk);
    endtask

    // drained and quiet: no step update left inside the block
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_radius();
        int k, r;
        k = $urandom_range(0, 9);
        if (k == 0)
            r = 0;
        else if (k < 8)
            r = $urandom_range(1, SMALL_RADIUS);
        else
            r = $urandom_range(SMALL_RADIUS + 1, 511);
        return {1'($urandom_range(0, 1)), RADIUS_BITS'(r)};
    endfunction

    initial begin
        int n, i, rnd_phase;
        logic [CFG_W-1:0] ra, rb;
        bit wide_rad, burst;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default registers, with an advance before any walk exists
        batch = '{BEAT_ADVANCE, BEAT_RESTART, BEAT_ADVANCE, BEAT_ADVANCE};
        launch(1'b0, 1'b0);

        // unit radii at the origin: negative coordinates wrap
        settle();
        set_ellipse(0, 0, 1, 1);
        batch = '{BEAT_RESTART, BEAT_ADVANCE, BEAT_ADVANCE, BEAT_ADVANCE};
        launch(1'b0, 1'b0);

        // flat ellipse: zero radius_b plots only the centre pixel
        settle();
        set_ellipse(1023, 1023, 5, 0);
        batch = '{BEAT_RESTART, BEAT_ADVANCE, BEAT_ADVANCE};
        launch(1'b0, 1'b0);

        // zero radius_a walks straight down in region two
        settle();
        set_ellipse(5, 0, 0, 3);
        batch = '{BEAT_RESTART, BEAT_ADVANCE, BEAT_ADVANCE, BEAT_ADVANCE, BEAT_ADVANCE};
        launch(1'b0, 1'b0);

        // largest radii (radius write masked), then centre and radius moved mid-walk
        settle();
        set_ellipse(0, 1023, 10'h3FF, 511);
        batch = '{BEAT_RESTART, BEAT_ADVANCE, BEAT_ADVANCE};
        launch(1'b0, 1'b0);
        settle();
        write_reg(REG_CENTER_X, 700);
        write_reg(REG_RADIUS_A, 300);
        batch = '{BEAT_ADVANCE, BEAT_ADVANCE};
        launch(1'b0, 1'b0);

        // tall thin ellipse: switches region after the first step, huge decision terms
        settle();
        set_ellipse(1023, 1023, 1, 511);
        batch = '{BEAT_RESTART, BEAT_ADVANCE, BEAT_ADVANCE};
        launch(1'b0, 1'b0);

        rnd_phase = 0;
        while (pushed < ITEM_TARGET) begin
            rnd_phase++;
            settle();
            ra = pick_radius();
            rb = pick_radius();
            set_ellipse($urandom_range(0, 1023), $urandom_range(0, 1023), ra, rb);
            wide_rad = (ra[RADIUS_BITS-1:0] > SMALL_RADIUS) ||
                       (rb[RADIUS_BITS-1:0] > SMALL_RADIUS);
            burst = (rnd_phase == 2) || ($urandom_range(0, 3) == 0);
            // mostly complete walks; sometimes carry on the old walk under new registers
            if ($urandom_range(0, 4) != 0)
                batch.push_back(BEAT_RESTART);
            n = wide_rad ? $urandom_range(10, 40)
                         : int'(ra[RADIUS_BITS-1:0]) + int'(rb[RADIUS_BITS-1:0]) + 2;
            for (i = 0; i < n; i++) begin
                if (rnd_phase == 4 && i == n / 2) begin
                    launch(burst, 1'b0);
                    wait_drained();
                end
                batch.push_back(($urandom_range(0, 19) == 0) ? BEAT_RESTART : BEAT_ADVANCE);
            end
            launch(burst, rnd_phase == 2);
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        if (pixel_due.size() != 0) begin
            errors++;
            $display("%0t ns: %0d pixels never arrived", $time, pixel_due.size());
        end

        $display("covered %0d input beats (%0d restarts) over %0d register settings",
                 taken, restarts, phases);
        $display("checked %0d pixels, %0d of them on final steps, %0d mismatches",
                 pixels_checked, final_pixels, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
